[hdl/assert_macros.svh]
// ============================================================================
// Assertion macros
// Shared concurrent-check macros for the lexer core. Define NO_ASSERTIONS to
// compile them away.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication check.
`define KLX_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("klx: implication check failed");
// Next-cycle implication check.
`define KLX_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("klx: next-cycle check failed");
`else
`define KLX_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define KLX_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[hdl/klx_pkg.sv]
// ============================================================================
// klx_pkg
// Types, character codes, token codes and table lookups of the keyword and
// operator lexer.
// ============================================================================
package klx_pkg;

    // Lexer modes.
    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_COMMENT,
        MODE_IDENT,
        MODE_NUMZERO,
        MODE_NUM,
        MODE_STRING,
        MODE_CHAROPEN,
        MODE_CHARBODY,
        MODE_OP
    } lex_mode_t;

    // One result token.
    typedef struct packed {
        logic [5:0]  tok_type;
        logic [23:0] start;
        logic [24:0] length;
        logic [1:0]  err;
    } token_t;

    // Up to three tokens caused by one source byte.
    typedef struct packed {
        logic [1:0]       count;
        token_t [2:0]     tok;
    } bundle_t;

    // Token type codes.
    localparam logic [5:0] TT_IDENT   = 6'd0;
    localparam logic [5:0] TT_NUMBER  = 6'd1;
    localparam logic [5:0] TT_STRING  = 6'd2;
    localparam logic [5:0] TT_CHAR    = 6'd3;
    localparam logic [5:0] TT_KW_BASE = 6'd4;

    localparam logic [5:0] OP_DOT         = 6'd26;
    localparam logic [5:0] OP_ELLIPSIS    = 6'd27;
    localparam logic [5:0] OP_LAND_ASSIGN = 6'd40;
    localparam logic [5:0] OP_LOR_ASSIGN  = 6'd41;

    // Error codes.
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_UNTERM   = 2'd1;
    localparam logic [1:0] ERR_NO_QUOTE = 2'd2;
    localparam logic [1:0] ERR_BADCHAR  = 2'd3;

    // Character codes.
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_US     = 8'h5f;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_BAR    = 8'h7c;
    localparam logic [7:0] CH_EQ     = 8'h3d;
    localparam logic [7:0] CH_DQ     = 8'h22;
    localparam logic [7:0] CH_SQ     = 8'h27;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_LT     = 8'h3c;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

    // Keyword table, text left-aligned and padded with zero bytes.
    localparam int unsigned NUM_KW = 15;
    localparam logic [47:0] KW_TEXT [NUM_KW] = '{
        "extern", {"fn", 32'h0}, {"var", 24'h0}, "struct", {"if", 32'h0},
        {"else", 16'h0}, {"for", 24'h0}, {"while", 8'h0}, "return",
        {"as", 32'h0}, {"self", 16'h0}, {"use", 24'h0}, {"mod", 24'h0},
        {"type", 16'h0}, {"macro", 8'h0}
    };
    localparam int unsigned KW_LEN [NUM_KW] = '{
        6, 2, 3, 6, 2, 4, 3, 5, 6, 2, 4, 3, 3, 4, 5
    };

    function automatic token_t mk_tok(input logic [5:0] t, input logic [23:0] s,
                                      input logic [24:0] l, input logic [1:0] e);
        token_t r;
        r.tok_type = t;
        r.start    = s;
        r.length   = l;
        r.err      = e;
        return r;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    endfunction

    // Single-character operator: valid flag.
    function automatic logic op1_valid(input logic [7:0] c);
        logic v;
        unique case (c)
            CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_LPAREN, CH_RPAREN,
            CH_COMMA, CH_DOT, CH_COLON, CH_SEMI, CH_DOLLAR, CH_EQ, CH_PLUS,
            CH_MINUS, CH_SLASH, CH_STAR, CH_AMP, CH_BAR, CH_LT, CH_GT,
            CH_BANG: v = 1'b1;
            default: v = 1'b0;
        endcase
        return v;
    endfunction

    // Single-character operator: type code.
    function automatic logic [5:0] op1_code(input logic [7:0] c);
        logic [5:0] r;
        unique case (c)
            CH_LBRACE: r = 6'd19;
            CH_RBRACE: r = 6'd20;
            CH_LBRACK: r = 6'd21;
            CH_RBRACK: r = 6'd22;
            CH_LPAREN: r = 6'd23;
            CH_RPAREN: r = 6'd24;
            CH_COMMA:  r = 6'd25;
            CH_DOT:    r = OP_DOT;
            CH_COLON:  r = 6'd28;
            CH_SEMI:   r = 6'd29;
            CH_DOLLAR: r = 6'd31;
            CH_EQ:     r = 6'd33;
            CH_PLUS:   r = 6'd42;
            CH_MINUS:  r = 6'd43;
            CH_SLASH:  r = 6'd44;
            CH_STAR:   r = 6'd45;
            CH_AMP:    r = 6'd46;
            CH_BAR:    r = 6'd47;
            CH_LT:     r = 6'd50;
            CH_GT:     r = 6'd52;
            CH_BANG:   r = 6'd56;
            default:   r = TT_IDENT;
        endcase
        return r;
    endfunction

    // A single-character operator that begins a longer one.
    function automatic logic op_ext1(input logic [7:0] c);
        logic v;
        unique case (c)
            CH_DOT, CH_COLON, CH_EQ, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
            CH_AMP, CH_BAR, CH_BANG, CH_LT, CH_GT: v = 1'b1;
            default: v = 1'b0;
        endcase
        return v;
    endfunction

    // Two-character operator: valid flag and code (bit 6 is the flag).
    function automatic logic [6:0] op2_lookup(input logic [7:0] a, input logic [7:0] b);
        logic [6:0] r;
        unique case ({a, b})
            {CH_MINUS, CH_GT}:    r = {1'b1, 6'd30};
            {CH_COLON, CH_COLON}: r = {1'b1, 6'd32};
            {CH_PLUS, CH_EQ}:     r = {1'b1, 6'd34};
            {CH_MINUS, CH_EQ}:    r = {1'b1, 6'd35};
            {CH_STAR, CH_EQ}:     r = {1'b1, 6'd36};
            {CH_SLASH, CH_EQ}:    r = {1'b1, 6'd37};
            {CH_AMP, CH_EQ}:      r = {1'b1, 6'd38};
            {CH_BAR, CH_EQ}:      r = {1'b1, 6'd39};
            {CH_EQ, CH_EQ}:       r = {1'b1, 6'd48};
            {CH_BANG, CH_EQ}:     r = {1'b1, 6'd49};
            {CH_LT, CH_EQ}:       r = {1'b1, 6'd51};
            {CH_GT, CH_EQ}:       r = {1'b1, 6'd53};
            {CH_AMP, CH_AMP}:     r = {1'b1, 6'd54};
            {CH_BAR, CH_BAR}:     r = {1'b1, 6'd55};
            default:              r = 7'd0;
        endcase
        return r;
    endfunction

    // Keyword lookup over the first six identifier bytes.
    function automatic logic [5:0] kw_code(input logic [5:0][7:0] w,
                                           input logic [24:0] len);
        logic [5:0] r;
        logic       hit;
        r = TT_IDENT;
        for (int k = 0; k < NUM_KW; k++) begin
            hit = (len == 25'(KW_LEN[k]));
            for (int i = 0; i < 6; i++) begin
                if (i < KW_LEN[k]) begin
                    hit = hit && (w[i] == KW_TEXT[k][47 - 8 * i -: 8]);
                end
            end
            if (hit) begin
                r = TT_KW_BASE + 6'(k);
            end
        end
        return r;
    endfunction

endpackage

[hdl/keyword_operator_lexer_core.sv]
// ============================================================================
// keyword_operator_lexer_core
// Streaming maximal-munch lexer: bytes in, tokens out.
// ============================================================================
// Source bytes arrive on the s_ channel, one request per byte, with
// s_end_of_text on the final byte of a text. Tokens leave on the m_ channel,
// one request per token, with m_last on the final token caused by a byte.
// cfg_data sets the source identifier echoed in m_file_tag; write it only
// while the lexer is idle.
// A byte is held in an input register and processed once the result register
// has room; its tokens are then registered there and offered on the m_ channel.
// The lexer takes one byte per cycle while each byte gives at most one token
// and m_ready stays high; a byte that gives two or three tokens holds input
// while the result register drains.
// If m_ready stays low the result register holds and the input side stops
// once the input register is full. Reset (aresetn low, synchronous) empties
// both registers, returns the lexer to idle at offset zero and clears the
// source identifier.
// ============================================================================
module keyword_operator_lexer_core #(
    parameter longint unsigned MAX_TEXT_BYTES  = 64'd16777216,
    parameter int unsigned     KEYWORD_MAX_LEN = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_end_of_text,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_token_kind,
    output logic [23:0] m_token_start,
    output logic [24:0] m_token_length,
    output logic [15:0] m_file_tag,
    output logic [1:0]  m_error_code,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic             in_vld_reg;
    logic [7:0]       in_byte_reg;
    logic             in_eot_reg;
    logic [15:0]      source_id_reg;
    logic             can_load;
    logic             step_go;
    klx_pkg::bundle_t res;
    klx_pkg::token_t  head;

    assign step_go   = in_vld_reg && can_load;
    assign s_ready   = !in_vld_reg || step_go;
    assign cfg_ready = 1'b1;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
            in_eot_reg  <= s_end_of_text;
        end
    end

    // Source identifier register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_id_reg <= 16'd0;
        end else if (cfg_valid && cfg_ready) begin
            source_id_reg <= cfg_data;
        end
    end

    klx_scan #(
        .MAX_TEXT_BYTES  (MAX_TEXT_BYTES),
        .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (step_go),
        .in_byte (in_byte_reg),
        .in_eot  (in_eot_reg),
        .res     (res)
    );

    klx_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step_go),
        .res       (res),
        .can_load  (can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .head      (head),
        .head_last (m_last)
    );

    assign m_token_kind   = head.tok_type;
    assign m_token_start  = head.start;
    assign m_token_length = head.length;
    assign m_error_code   = head.err;
    assign m_file_tag     = source_id_reg;

endmodule

[hdl/klx_scan.sv]
// ============================================================================
// klx_scan
// Lexer state and the single-pass transition for one source byte, giving up
// to three tokens per byte.
// ============================================================================
`include "assert_macros.svh"

module klx_scan #(
    parameter longint unsigned MAX_TEXT_BYTES  = 64'd16777216,
    parameter int unsigned     KEYWORD_MAX_LEN = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             go,
    input  logic [7:0]       in_byte,
    input  logic             in_eot,
    output klx_pkg::bundle_t res
);

    localparam logic [24:0] LEN_CAP = (MAX_TEXT_BYTES < 64'h1FFFFFF) ?
                                      MAX_TEXT_BYTES[24:0] : 25'h1FFFFFF;
    localparam int unsigned KML = KEYWORD_MAX_LEN;

    klx_pkg::lex_mode_t   mode_reg, mode_next, d_mode;
    logic [23:0]          pos_reg, pos_next;
    logic [23:0]          tbeg_reg, tbeg_next, d_tbeg;
    logic [24:0]          tlen_reg, tlen_next, d_tlen, tlen_grow;
    logic [KML-1:0][7:0]  word_reg, word_next, d_word;
    logic [7:0]           p0_reg, p0_next, d_p0;
    logic [1:0]           pn_reg, pn_next, d_pn;
    logic                 hex_reg, hex_next, d_hex;
    logic                 d_ev;
    klx_pkg::token_t      d_tok;
    klx_pkg::token_t      cand [5];
    logic [4:0]           cv;
    logic [6:0]           pair;
    logic                 num_ok;

    assign tlen_grow = (tlen_reg < LEN_CAP) ? tlen_reg + 25'd1 : tlen_reg;
    assign pair      = klx_pkg::op2_lookup(p0_reg, in_byte);
    assign num_ok    = klx_pkg::is_digit(in_byte) || (in_byte == klx_pkg::CH_DOT) ||
                       (hex_reg && klx_pkg::is_hex(in_byte));

    // Start of a new lexeme from the idle mode.
    always_comb begin
        d_mode = klx_pkg::MODE_IDLE;
        d_tbeg = tbeg_reg;
        d_tlen = tlen_reg;
        d_word = word_reg;
        d_p0   = p0_reg;
        d_pn   = 2'd0;
        d_hex  = hex_reg;
        d_ev   = 1'b0;
        d_tok  = '0;
        if (in_byte == klx_pkg::CH_SP || in_byte == klx_pkg::CH_LF ||
            in_byte == klx_pkg::CH_TAB || in_byte == klx_pkg::CH_CR) begin
            d_mode = klx_pkg::MODE_IDLE;
        end else if (in_byte == klx_pkg::CH_HASH) begin
            d_mode = klx_pkg::MODE_COMMENT;
        end else begin
            d_tbeg = pos_reg;
            d_tlen = 25'd1;
            priority if (klx_pkg::op1_valid(in_byte)) begin
                d_p0 = in_byte;
                if (klx_pkg::op_ext1(in_byte)) begin
                    d_mode = klx_pkg::MODE_OP;
                    d_pn   = 2'd1;
                end else begin
                    d_ev   = 1'b1;
                    d_tok  = klx_pkg::mk_tok(klx_pkg::op1_code(in_byte), pos_reg, 25'd1,
                                             klx_pkg::ERR_NONE);
                    d_tbeg = pos_reg + 24'd1;
                end
            end else if (klx_pkg::is_alpha(in_byte) || in_byte == klx_pkg::CH_US) begin
                d_word    = '0;
                d_word[0] = in_byte;
                d_mode    = klx_pkg::MODE_IDENT;
            end else if (klx_pkg::is_digit(in_byte)) begin
                d_hex  = 1'b0;
                d_mode = (in_byte == 8'h30) ? klx_pkg::MODE_NUMZERO : klx_pkg::MODE_NUM;
            end else if (in_byte == klx_pkg::CH_DQ) begin
                d_tbeg = pos_reg + 24'd1;
                d_tlen = 25'd0;
                d_mode = klx_pkg::MODE_STRING;
            end else if (in_byte == klx_pkg::CH_SQ) begin
                d_mode = klx_pkg::MODE_CHAROPEN;
            end else begin
                d_ev  = 1'b1;
                d_tok = klx_pkg::mk_tok(klx_pkg::TT_IDENT, pos_reg, 25'd1,
                                        klx_pkg::ERR_BADCHAR);
            end
        end
    end

    // Mode transition, emitted candidates and end-of-text flush.
    always_comb begin
        mode_next = mode_reg;
        pos_next  = pos_reg + 24'd1;
        tbeg_next = tbeg_reg;
        tlen_next = tlen_reg;
        word_next = word_reg;
        p0_next   = p0_reg;
        pn_next   = pn_reg;
        hex_next  = hex_reg;
        cv        = '0;
        for (int i = 0; i < 5; i++) begin
            cand[i] = '0;
        end

        unique case (mode_reg)
            klx_pkg::MODE_COMMENT: begin
                if (in_byte == klx_pkg::CH_LF) begin
                    mode_next = klx_pkg::MODE_IDLE;
                end
            end
            klx_pkg::MODE_IDENT: begin
                if (klx_pkg::is_alpha(in_byte) || klx_pkg::is_digit(in_byte) ||
                    in_byte == klx_pkg::CH_US) begin
                    for (int i = 0; i < KML; i++) begin
                        if (tlen_reg == 25'(i)) begin
                            word_next[i] = in_byte;
                        end
                    end
                    tlen_next = tlen_grow;
                end else begin
                    cv[0]   = 1'b1;
                    cand[0] = klx_pkg::mk_tok(klx_pkg::kw_code(word_reg[5:0], tlen_reg),
                                              tbeg_reg, tlen_reg, klx_pkg::ERR_NONE);
                    mode_next = d_mode; tbeg_next = d_tbeg; tlen_next = d_tlen;
                    word_next = d_word; p0_next = d_p0; pn_next = d_pn; hex_next = d_hex;
                    cv[2] = d_ev; cand[2] = d_tok;
                end
            end
            klx_pkg::MODE_NUMZERO, klx_pkg::MODE_NUM: begin
                if (mode_reg == klx_pkg::MODE_NUMZERO &&
                    (in_byte == klx_pkg::CH_X || in_byte == klx_pkg::CH_B)) begin
                    hex_next  = (in_byte == klx_pkg::CH_X);
                    tlen_next = tlen_grow;
                    mode_next = klx_pkg::MODE_NUM;
                end else if (num_ok) begin
                    tlen_next = tlen_grow;
                    mode_next = klx_pkg::MODE_NUM;
                end else begin
                    cv[0]   = 1'b1;
                    cand[0] = klx_pkg::mk_tok(klx_pkg::TT_NUMBER, tbeg_reg, tlen_reg,
                                              klx_pkg::ERR_NONE);
                    mode_next = d_mode; tbeg_next = d_tbeg; tlen_next = d_tlen;
                    word_next = d_word; p0_next = d_p0; pn_next = d_pn; hex_next = d_hex;
                    cv[2] = d_ev; cand[2] = d_tok;
                end
            end
            klx_pkg::MODE_STRING: begin
                if (in_byte == klx_pkg::CH_DQ) begin
                    cv[0]     = 1'b1;
                    cand[0]   = klx_pkg::mk_tok(klx_pkg::TT_STRING, tbeg_reg, tlen_reg,
                                                klx_pkg::ERR_NONE);
                    mode_next = klx_pkg::MODE_IDLE;
                end else begin
                    tlen_next = tlen_grow;
                end
            end
            klx_pkg::MODE_CHAROPEN: begin
                tlen_next = 25'd2;
                mode_next = klx_pkg::MODE_CHARBODY;
            end
            klx_pkg::MODE_CHARBODY: begin
                cv[0]   = 1'b1;
                cand[0] = klx_pkg::mk_tok(klx_pkg::TT_CHAR, tbeg_reg, 25'd3,
                                          klx_pkg::ERR_NONE);
                if (in_byte != klx_pkg::CH_SQ) begin
                    cv[1]   = 1'b1;
                    cand[1] = klx_pkg::mk_tok(klx_pkg::TT_CHAR, pos_reg, 25'd1,
                                              klx_pkg::ERR_NO_QUOTE);
                end
                mode_next = klx_pkg::MODE_IDLE;
            end
            klx_pkg::MODE_OP: begin
                if (pn_reg == 2'd1) begin
                    if (in_byte == p0_reg && (p0_reg == klx_pkg::CH_DOT ||
                        p0_reg == klx_pkg::CH_AMP || p0_reg == klx_pkg::CH_BAR)) begin
                        // Two-byte prefix of a three-byte operator stays pending.
                        pn_next = 2'd2;
                    end else if (pair[6]) begin
                        cv[0]     = 1'b1;
                        cand[0]   = klx_pkg::mk_tok(pair[5:0], tbeg_reg, 25'd2,
                                                    klx_pkg::ERR_NONE);
                        pn_next   = 2'd0;
                        tbeg_next = tbeg_reg + 24'd2;
                        mode_next = klx_pkg::MODE_IDLE;
                    end else begin
                        cv[0]   = 1'b1;
                        cand[0] = klx_pkg::mk_tok(klx_pkg::op1_code(p0_reg), tbeg_reg,
                                                  25'd1, klx_pkg::ERR_NONE);
                        mode_next = d_mode; tbeg_next = d_tbeg; tlen_next = d_tlen;
                        word_next = d_word; p0_next = d_p0; pn_next = d_pn;
                        hex_next = d_hex; cv[2] = d_ev; cand[2] = d_tok;
                    end
                end else begin
                    if ((p0_reg == klx_pkg::CH_DOT && in_byte == klx_pkg::CH_DOT) ||
                        (p0_reg != klx_pkg::CH_DOT && in_byte == klx_pkg::CH_EQ)) begin
                        cv[0]   = 1'b1;
                        cand[0] = klx_pkg::mk_tok(
                            (p0_reg == klx_pkg::CH_DOT) ? klx_pkg::OP_ELLIPSIS :
                            (p0_reg == klx_pkg::CH_AMP) ? klx_pkg::OP_LAND_ASSIGN :
                                                          klx_pkg::OP_LOR_ASSIGN,
                            tbeg_reg, 25'd3, klx_pkg::ERR_NONE);
                        pn_next   = 2'd0;
                        tbeg_next = tbeg_reg + 24'd3;
                        mode_next = klx_pkg::MODE_IDLE;
                    end else begin
                        // Fall back to the longest complete operator.
                        cv[0] = 1'b1;
                        if (p0_reg == klx_pkg::CH_DOT) begin
                            cand[0] = klx_pkg::mk_tok(klx_pkg::OP_DOT, tbeg_reg, 25'd1,
                                                      klx_pkg::ERR_NONE);
                            cv[1]   = 1'b1;
                            cand[1] = klx_pkg::mk_tok(klx_pkg::OP_DOT, tbeg_reg + 24'd1,
                                                      25'd1, klx_pkg::ERR_NONE);
                        end else begin
                            cand[0] = klx_pkg::mk_tok(
                                6'(klx_pkg::op2_lookup(p0_reg, p0_reg)),
                                tbeg_reg, 25'd2, klx_pkg::ERR_NONE);
                        end
                        mode_next = d_mode; tbeg_next = d_tbeg; tlen_next = d_tlen;
                        word_next = d_word; p0_next = d_p0; pn_next = d_pn;
                        hex_next = d_hex; cv[2] = d_ev; cand[2] = d_tok;
                    end
                end
            end
            default: begin
                mode_next = d_mode; tbeg_next = d_tbeg; tlen_next = d_tlen;
                word_next = d_word; p0_next = d_p0; pn_next = d_pn; hex_next = d_hex;
                cv[2] = d_ev; cand[2] = d_tok;
            end
        endcase

        // End of text: flush whatever lexeme is open, then rewind.
        if (in_eot) begin
            unique case (mode_next)
                klx_pkg::MODE_IDENT: begin
                    cv[3]   = 1'b1;
                    cand[3] = klx_pkg::mk_tok(klx_pkg::kw_code(word_next[5:0], tlen_next),
                                              tbeg_next, tlen_next, klx_pkg::ERR_NONE);
                end
                klx_pkg::MODE_NUMZERO, klx_pkg::MODE_NUM: begin
                    cv[3]   = 1'b1;
                    cand[3] = klx_pkg::mk_tok(klx_pkg::TT_NUMBER, tbeg_next, tlen_next,
                                              klx_pkg::ERR_NONE);
                end
                klx_pkg::MODE_STRING: begin
                    cv[3]   = 1'b1;
                    cand[3] = klx_pkg::mk_tok(klx_pkg::TT_STRING, tbeg_next, tlen_next,
                                              klx_pkg::ERR_UNTERM);
                end
                klx_pkg::MODE_CHAROPEN, klx_pkg::MODE_CHARBODY: begin
                    cv[3]   = 1'b1;
                    cand[3] = klx_pkg::mk_tok(klx_pkg::TT_CHAR, tbeg_next, tlen_next,
                                              klx_pkg::ERR_NO_QUOTE);
                end
                klx_pkg::MODE_OP: begin
                    cv[3] = 1'b1;
                    if (pn_next == 2'd1) begin
                        cand[3] = klx_pkg::mk_tok(klx_pkg::op1_code(p0_next), tbeg_next,
                                                  25'd1, klx_pkg::ERR_NONE);
                    end else if (p0_next == klx_pkg::CH_DOT) begin
                        cand[3] = klx_pkg::mk_tok(klx_pkg::OP_DOT, tbeg_next, 25'd1,
                                                  klx_pkg::ERR_NONE);
                        cv[4]   = 1'b1;
                        cand[4] = klx_pkg::mk_tok(klx_pkg::OP_DOT, tbeg_next + 24'd1,
                                                  25'd1, klx_pkg::ERR_NONE);
                    end else begin
                        cand[3] = klx_pkg::mk_tok(
                            6'(klx_pkg::op2_lookup(p0_next, p0_next)),
                            tbeg_next, 25'd2, klx_pkg::ERR_NONE);
                    end
                end
                default: begin
                end
            endcase
            mode_next = klx_pkg::MODE_IDLE;
            pos_next  = 24'd0;
            pn_next   = 2'd0;
            hex_next  = 1'b0;
        end
    end

    // Pack the candidates in order, at most three.
    always_comb begin
        res = '0;
        for (int i = 0; i < 5; i++) begin
            if (cv[i] && res.count != 2'd3) begin
                res.tok[res.count] = cand[i];
                res.count          = res.count + 2'd1;
            end
        end
    end

    // State registers advance once per processed byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= klx_pkg::MODE_IDLE;
            pos_reg  <= '0;
            tbeg_reg <= '0;
            tlen_reg <= '0;
            word_reg <= '0;
            p0_reg   <= '0;
            pn_reg   <= '0;
            hex_reg  <= 1'b0;
        end else if (go) begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            tbeg_reg <= tbeg_next;
            tlen_reg <= tlen_next;
            word_reg <= word_next;
            p0_reg   <= p0_next;
            pn_reg   <= pn_next;
            hex_reg  <= hex_next;
        end
    end

    `KLX_ASSERT_IMP(a_op_pending, aclk, aresetn, mode_reg == klx_pkg::MODE_OP, pn_reg != 2'd0)
    `KLX_ASSERT_IMP(a_pend_idle, aclk, aresetn, mode_reg == klx_pkg::MODE_IDLE,
                    pn_reg == 2'd0)
    `KLX_ASSERT_IMP(a_tlen_cap, aclk, aresetn, 1'b1, tlen_reg <= LEN_CAP)

endmodule

[hdl/klx_out.sv]
// ============================================================================
// klx_out
// Result register holding the tokens of one byte and handing them out one
// request at a time.
// ============================================================================
`include "assert_macros.svh"

module klx_out (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  klx_pkg::bundle_t res,
    output logic             can_load,
    output logic             m_valid,
    input  logic             m_ready,
    output klx_pkg::token_t  head,
    output logic             head_last
);

    klx_pkg::bundle_t bundle_reg;
    logic             take;

    assign m_valid   = bundle_reg.count != 2'd0;
    assign take      = m_valid && m_ready;
    assign can_load  = (bundle_reg.count == 2'd0) || (bundle_reg.count == 2'd1 && m_ready);
    assign head      = bundle_reg.tok[0];
    assign head_last = bundle_reg.count == 2'd1;

    // Load a new group or shift the next token to the head.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bundle_reg.count <= 2'd0;
        end else if (load) begin
            bundle_reg <= res;
        end else if (take) begin
            bundle_reg.count  <= bundle_reg.count - 2'd1;
            bundle_reg.tok[0] <= bundle_reg.tok[1];
            bundle_reg.tok[1] <= bundle_reg.tok[2];
        end
    end

    `KLX_ASSERT_IMP(a_load_room, aclk, aresetn, load,
                    bundle_reg.count == 2'd0 || (bundle_reg.count == 2'd1 && m_ready))
    `KLX_ASSERT_NXT(a_drain_step, aclk, aresetn, take && !load,
                    bundle_reg.count == $past(bundle_reg.count) - 2'd1)
    `KLX_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready,
                    bundle_reg.count == $past(bundle_reg.count))

endmodule

[bench/keyword_operator_lexer_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// Lexer token checker
// Watches the byte, token and source-identifier channels of the lexer core.
// It runs its own maximal-munch tokeniser on every accepted byte and queues
// the tokens that byte should produce. Each accepted token is compared field
// by field with the oldest queued one.
// ============================================================================
module keyword_operator_lexer_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_end_of_text,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [5:0]  m_token_kind,
    input  logic [23:0] m_token_start,
    input  logic [24:0] m_token_length,
    input  logic [15:0] m_file_tag,
    input  logic [1:0]  m_error_code,
    input  logic        m_last,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          tokens_pending
);

    typedef struct {
        logic [5:0]  ty;
        logic [23:0] st;
        logic [24:0] ln;
        logic [15:0] tag;
        logic [1:0]  er;
        logic        lst;
    } token_rec_t;

    localparam logic [24:0] LEN_LIMIT = 25'd16777216;

    // Operators in token-code order, starting at code 19.
    string op_tab [38] = '{
        "{", "}", "[", "]", "(", ")", ",", ".", "...", ":", ";", "->", "$", "::",
        "=", "+=", "-=", "*=", "/=", "&=", "|=", "&&=", "||=", "+", "-", "/", "*",
        "&", "|", "==", "!=", "<", "<=", ">", ">=", "&&", "||", "!"
    };
    // Keywords in token-code order, starting at code 4.
    string kw_tab [15] = '{
        "extern", "fn", "var", "struct", "if", "else", "for", "while",
        "return", "as", "self", "use", "mod", "type", "macro"
    };

    token_rec_t  token_fifo [$];
    token_rec_t  step_toks [3];
    int          step_count;

    // Tokeniser state.
    klx_pkg::lex_mode_t mode;
    logic [23:0] pos;
    logic [23:0] tbeg;
    logic [7:0]  wbuf [6];
    logic [7:0]  pend [4];
    int          pend_n;
    logic        hex_ok;
    logic [24:0] tlen;
    logic [15:0] source_tag;

    assign tokens_pending = token_fifo.size();

    function automatic logic letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic decimal(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic hexdig(input logic [7:0] c);
        return decimal(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    // True when the first n bytes of s equal the first n bytes of operator i.
    function automatic logic op_head(input int i, input logic [7:0] s [4], input int n);
        for (int k = 0; k < n; k++) begin
            if (op_tab[i][k] != s[k]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int op_exact(input logic [7:0] s [4], input int n);
        for (int i = 0; i < 38; i++) begin
            if (op_tab[i].len() == n && op_head(i, s, n)) return i;
        end
        return -1;
    endfunction

    function automatic logic op_grows(input logic [7:0] s [4], input int n,
                                      input logic strict);
        int l;
        for (int i = 0; i < 38; i++) begin
            l = op_tab[i].len();
            if ((strict ? l > n : l >= n) && op_head(i, s, n)) return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic add_tok(input logic [5:0] ty, input logic [23:0] st,
                           input logic [24:0] ln, input logic [1:0] er);
        if (step_count < 3) begin
            step_toks[step_count] = '{ty, st, ln, source_tag, er, 1'b0};
            step_count++;
        end
    endtask

    task automatic grow();
        if (tlen < LEN_LIMIT) tlen++;
    endtask

    // Emit the longest complete operator at the head of the pending bytes.
    task automatic flush_one();
        int best;
        int idx;
        int k;
        best = 0;
        idx = -1;
        for (int l = 1; l <= pend_n; l++) begin
            k = op_exact(pend, l);
            if (k >= 0) begin
                idx = k;
                best = l;
            end
        end
        if (idx < 0) begin
            add_tok(klx_pkg::TT_IDENT, tbeg, 25'd1, klx_pkg::ERR_BADCHAR);
            best = 1;
        end else begin
            add_tok(6'(19 + idx), tbeg, 25'(best), klx_pkg::ERR_NONE);
        end
        for (int j = 0; j + best < 3; j++) pend[j] = pend[j + best];
        pend_n -= best;
        tbeg = tbeg + 24'(best);
    endtask

    task automatic finish_word();
        logic [5:0] ty;
        logic       hit;
        int         l;
        ty = klx_pkg::TT_IDENT;
        for (int k = 0; k < 15; k++) begin
            l = kw_tab[k].len();
            hit = (tlen == 25'(l));
            for (int i = 0; i < l; i++) begin
                if (hit && wbuf[i] != kw_tab[k][i]) hit = 1'b0;
            end
            if (hit) ty = klx_pkg::TT_KW_BASE + 6'(k);
        end
        add_tok(ty, tbeg, tlen, klx_pkg::ERR_NONE);
    endtask

    // Begin a new lexeme, or skip, from the idle mode.
    task automatic start_lexeme(input logic [7:0] b);
        logic [7:0] probe [4];
        mode = klx_pkg::MODE_IDLE;
        probe = '{b, 8'h0, 8'h0, 8'h0};
        if (b == klx_pkg::CH_SP || b == klx_pkg::CH_LF || b == klx_pkg::CH_TAB ||
            b == klx_pkg::CH_CR) return;
        if (b == klx_pkg::CH_HASH) begin
            mode = klx_pkg::MODE_COMMENT;
            return;
        end
        tbeg = pos;
        tlen = 25'd1;
        if (op_grows(probe, 1, 1'b0)) begin
            pend[0] = b;
            pend_n = 1;
            if (op_grows(pend, 1, 1'b1)) mode = klx_pkg::MODE_OP;
            else flush_one();
        end else if (letter(b) || b == klx_pkg::CH_US) begin
            foreach (wbuf[i]) wbuf[i] = 8'h0;
            wbuf[0] = b;
            mode = klx_pkg::MODE_IDENT;
        end else if (decimal(b)) begin
            hex_ok = 1'b0;
            mode = (b == "0") ? klx_pkg::MODE_NUMZERO : klx_pkg::MODE_NUM;
        end else if (b == klx_pkg::CH_DQ) begin
            tbeg = pos + 24'd1;
            tlen = 25'd0;
            mode = klx_pkg::MODE_STRING;
        end else if (b == klx_pkg::CH_SQ) begin
            mode = klx_pkg::MODE_CHAROPEN;
        end else begin
            add_tok(klx_pkg::TT_IDENT, pos, 25'd1, klx_pkg::ERR_BADCHAR);
        end
    endtask

    task automatic op_byte(input logic [7:0] b);
        logic [7:0] probe [4];
        while (pend_n > 0) begin
            if (pend_n < 3) begin
                probe = pend;
                probe[pend_n] = b;
                if (op_grows(probe, pend_n + 1, 1'b0)) break;
            end
            flush_one();
        end
        if (pend_n == 0) begin
            start_lexeme(b);
            return;
        end
        pend[pend_n] = b;
        pend_n++;
        if (!op_grows(pend, pend_n, 1'b1)) begin
            flush_one();
            if (pend_n == 0) mode = klx_pkg::MODE_IDLE;
        end
    endtask

    task automatic number_step(input logic [7:0] b);
        if (decimal(b) || b == klx_pkg::CH_DOT || (hex_ok && hexdig(b))) begin
            grow();
            mode = klx_pkg::MODE_NUM;
        end else begin
            add_tok(klx_pkg::TT_NUMBER, tbeg, tlen, klx_pkg::ERR_NONE);
            start_lexeme(b);
        end
    endtask

    task automatic close_text();
        case (mode)
            klx_pkg::MODE_IDENT: finish_word();
            klx_pkg::MODE_NUMZERO, klx_pkg::MODE_NUM:
                add_tok(klx_pkg::TT_NUMBER, tbeg, tlen, klx_pkg::ERR_NONE);
            klx_pkg::MODE_STRING:
                add_tok(klx_pkg::TT_STRING, tbeg, tlen, klx_pkg::ERR_UNTERM);
            klx_pkg::MODE_CHAROPEN, klx_pkg::MODE_CHARBODY:
                add_tok(klx_pkg::TT_CHAR, tbeg, tlen, klx_pkg::ERR_NO_QUOTE);
            klx_pkg::MODE_OP: while (pend_n > 0) flush_one();
            default: ;
        endcase
    endtask

    // Work out every token caused by one source byte and queue them.
    task automatic lex_byte(input logic [7:0] b, input logic eot);
        step_count = 0;
        case (mode)
            klx_pkg::MODE_COMMENT: if (b == klx_pkg::CH_LF) mode = klx_pkg::MODE_IDLE;
            klx_pkg::MODE_IDENT: begin
                if (letter(b) || decimal(b) || b == klx_pkg::CH_US) begin
                    if (tlen < 25'd6) wbuf[tlen] = b;
                    grow();
                end else begin
                    finish_word();
                    start_lexeme(b);
                end
            end
            klx_pkg::MODE_NUMZERO: begin
                if (b == klx_pkg::CH_X || b == klx_pkg::CH_B) begin
                    hex_ok = (b == klx_pkg::CH_X);
                    grow();
                    mode = klx_pkg::MODE_NUM;
                end else begin
                    number_step(b);
                end
            end
            klx_pkg::MODE_NUM: number_step(b);
            klx_pkg::MODE_STRING: begin
                if (b == klx_pkg::CH_DQ) begin
                    add_tok(klx_pkg::TT_STRING, tbeg, tlen, klx_pkg::ERR_NONE);
                    mode = klx_pkg::MODE_IDLE;
                end else begin
                    grow();
                end
            end
            klx_pkg::MODE_CHAROPEN: begin
                tlen = 25'd2;
                mode = klx_pkg::MODE_CHARBODY;
            end
            klx_pkg::MODE_CHARBODY: begin
                add_tok(klx_pkg::TT_CHAR, tbeg, 25'd3, klx_pkg::ERR_NONE);
                if (b != klx_pkg::CH_SQ) begin
                    add_tok(klx_pkg::TT_CHAR, pos, 25'd1, klx_pkg::ERR_NO_QUOTE);
                end
                mode = klx_pkg::MODE_IDLE;
            end
            klx_pkg::MODE_OP: op_byte(b);
            default: start_lexeme(b);
        endcase
        pos = pos + 24'd1;
        if (eot) begin
            close_text();
            mode = klx_pkg::MODE_IDLE;
            pos = '0;
            pend_n = 0;
            hex_ok = 1'b0;
        end
        if (step_count > 0) step_toks[step_count - 1].lst = 1'b1;
        for (int i = 0; i < step_count; i++) begin
            token_fifo.insert(token_fifo.size(), step_toks[i]);
        end
    endtask

    task automatic check_field(input string name, input longint unsigned exp_v,
                               input longint unsigned got_v);
        if (exp_v != got_v) begin
            $error("token %s: expected %0d, got %0d", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    initial fail_count = 0;

    // Prediction on accepted bytes, comparison on accepted tokens.
    always @(posedge aclk) begin
        token_rec_t e;
        if (!aresetn) begin
            mode = klx_pkg::MODE_IDLE;
            pos = '0;
            tbeg = '0;
            foreach (wbuf[i]) wbuf[i] = 8'h0;
            pend = '{8'h0, 8'h0, 8'h0, 8'h0};
            pend_n = 0;
            hex_ok = 1'b0;
            tlen = '0;
            source_tag = '0;
            token_fifo.delete();
        end else begin
            if (cfg_valid && cfg_ready) source_tag = cfg_data;
            if (s_valid && s_ready) lex_byte(s_in_byte, s_end_of_text);
            if (m_valid && m_ready) begin
                if (token_fifo.size() == 0) begin
                    $error("token with nothing expected: kind %0d start %0d",
                           m_token_kind, m_token_start);
                    fail_count++;
                end else begin
                    e = token_fifo.pop_front();
                    check_field("token_kind", e.ty, m_token_kind);
                    check_field("token_start", e.st, m_token_start);
                    check_field("token_length", e.ln, m_token_length);
                    check_field("file_tag", e.tag, m_file_tag);
                    check_field("error_code", e.er, m_error_code);
                    check_field("last", e.lst, m_last);
                end
            end
        end
    end

endmodule

[bench/keyword_operator_lexer_core_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// Lexer core testbench
// Feeds the lexer short directed texts and then random source texts built
// from keywords, names, numbers, strings, char literals, operator runs,
// comments, blanks and stray bytes, with random gaps and output stalls. The
// checker beside the core predicts and compares every token.
// ============================================================================
module keyword_operator_lexer_core_tb;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_in_byte;
    logic        s_end_of_text;
    logic        m_valid;
    logic        m_ready;
    logic [5:0]  m_token_kind;
    logic [23:0] m_token_start;
    logic [24:0] m_token_length;
    logic [15:0] m_file_tag;
    logic [1:0]  m_error_code;
    logic        m_last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    int          fail_count;
    int          tokens_pending;

    logic [7:0]  text_bytes [$];
    logic        text_ends [$];
    int          burst_left;
    int          bytes_sent;
    logic        long_hold_req;

    keyword_operator_lexer_core u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_end_of_text  (s_end_of_text),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_token_start  (m_token_start),
        .m_token_length (m_token_length),
        .m_file_tag     (m_file_tag),
        .m_error_code   (m_error_code),
        .m_last         (m_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    keyword_operator_lexer_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_end_of_text  (s_end_of_text),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_token_start  (m_token_start),
        .m_token_length (m_token_length),
        .m_file_tag     (m_file_tag),
        .m_error_code   (m_error_code),
        .m_last         (m_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .tokens_pending (tokens_pending)
    );

    // Clock with a 2 ns period.
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Overall time limit.
    initial begin
        #600000;
        $display("Regression FAIL");
        $finish;
    end

    // Token receiver: changes its stall pattern every so often, and once
    // holds off for a long stretch while bytes keep arriving.
    initial begin
        int pattern;
        int tick;
        logic hold_done;
        m_ready = 1'b0;
        pattern = 0;
        tick = 0;
        hold_done = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold_req && !hold_done) begin
                m_ready <= 1'b0;
                hold_done = 1'b1;
                repeat (300) @(negedge aclk);
            end else begin
                tick++;
                if (tick % 64 == 0) pattern = $urandom_range(0, 3);
                case (pattern)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 1) == 1);
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    task automatic put_char(input logic [7:0] c);
        text_bytes.insert(text_bytes.size(), c);
        text_ends.insert(text_ends.size(), 1'b0);
    endtask

    task automatic put_text(input string s, input logic eot);
        for (int i = 0; i < s.len(); i++) put_char(s[i]);
        if (eot) text_ends[$] = 1'b1;
    endtask

    task automatic put_name_char();
        case ($urandom_range(0, 3))
            0: put_char(8'($urandom_range("a", "z")));
            1: put_char(8'($urandom_range("A", "Z")));
            2: put_char(8'($urandom_range("0", "9")));
            default: put_char(klx_pkg::CH_US);
        endcase
    endtask

    // One random lexeme, or a piece of noise.
    task automatic put_lexeme(input logic at_end);
        int k;
        int n;
        string op_chars;
        op_chars = "{}[](),.:;$=+-*/&|<>!";
        case ($urandom_range(0, 11))
            0, 1: begin
                k = $urandom_range(0, klx_pkg::NUM_KW - 1);
                for (int i = 0; i < klx_pkg::KW_LEN[k]; i++) begin
                    put_char(klx_pkg::KW_TEXT[k][47 - 8 * i -: 8]);
                end
                if ($urandom_range(0, 3) == 0) put_name_char();
            end
            2: begin
                put_char($urandom_range(0, 1) ? 8'($urandom_range("a", "z")) :
                                                klx_pkg::CH_US);
                n = $urandom_range(0, 8);
                repeat (n) put_name_char();
            end
            3: begin
                n = $urandom_range(0, 6);
                case ($urandom_range(0, 2))
                    0: begin
                        put_text("0x", 1'b0);
                        repeat (n) put_char(8'($urandom_range(0, 1) ?
                            $urandom_range("a", "f") : $urandom_range("A", "F")));
                    end
                    1: begin
                        put_text("0b", 1'b0);
                        repeat (n) put_char(8'($urandom_range("0", "1")));
                    end
                    default: begin
                        put_char(8'($urandom_range("0", "9")));
                        repeat (n) put_char($urandom_range(0, 3) == 0 ? klx_pkg::CH_DOT :
                                            8'($urandom_range("0", "9")));
                    end
                endcase
            end
            4: begin
                put_char(klx_pkg::CH_DQ);
                n = $urandom_range(0, 8);
                repeat (n) begin
                    k = $urandom_range(32, 126);
                    put_char(k == klx_pkg::CH_DQ ? klx_pkg::CH_SP : 8'(k));
                end
                if (!(at_end && $urandom_range(0, 2) == 0)) put_char(klx_pkg::CH_DQ);
            end
            5: begin
                put_char(klx_pkg::CH_SQ);
                if (!(at_end && $urandom_range(0, 3) == 0)) begin
                    put_char(8'($urandom_range(0, 255)));
                    if (!(at_end && $urandom_range(0, 2) == 0)) begin
                        put_char($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                                           : klx_pkg::CH_SQ);
                    end
                end
            end
            6, 7, 8: begin
                n = $urandom_range(1, 4);
                repeat (n) put_char(op_chars[$urandom_range(0, op_chars.len() - 1)]);
            end
            9: begin
                put_char(klx_pkg::CH_HASH);
                n = $urandom_range(0, 6);
                repeat (n) put_char(8'($urandom_range(32, 126)));
                put_char(klx_pkg::CH_LF);
            end
            10: begin
                case ($urandom_range(0, 3))
                    0: put_char(klx_pkg::CH_SP);
                    1: put_char(klx_pkg::CH_TAB);
                    2: put_char(klx_pkg::CH_CR);
                    default: put_char(klx_pkg::CH_LF);
                endcase
            end
            default: put_char(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic build_text();
        int n;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
            put_lexeme(i == n - 1);
            if (i < n - 1 && $urandom_range(0, 1) == 0) put_char(klx_pkg::CH_SP);
        end
        text_ends[$] = 1'b1;
    endtask

    // Offer one byte, in bursts with random gaps between them.
    task automatic send_byte(input logic [7:0] c, input logic eot);
        if (burst_left == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 12);
        end
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_in_byte     <= c;
        s_end_of_text <= eot;
        burst_left--;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic send_queued();
        while (text_bytes.size() > 0) send_byte(text_bytes.pop_front(), text_ends.pop_front());
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tokens_pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_source_id(input logic [15:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stimulus and verdict.
    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_in_byte     = 8'h0;
        s_end_of_text = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = 16'h0;
        long_hold_req = 1'b0;
        burst_left    = 0;
        bytes_sent    = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed texts: keyword and dot fallback, hex number, char literal
        // lacking its closing quote, unterminated string, stray high byte,
        // text ending inside a char literal and inside an operator.
        write_source_id(16'hFFFF);
        put_text("if ..x 0xAf", 1'b1);
        put_text("'ab\"q", 1'b1);
        put_char(8'hFF);
        put_text("'", 1'b1);
        put_text("&&=||...", 1'b0);
        put_char(8'h00);
        put_text("0b1:", 1'b1);
        send_queued();
        wait_drained();

        write_source_id(16'h0000);
        long_hold_req = 1'b1;
        while (bytes_sent < 250) begin
            build_text();
            send_queued();
        end
        wait_drained();

        write_source_id(16'($urandom_range(1, 16'hFFFE)));
        while (bytes_sent < 455) begin
            build_text();
            send_queued();
        end
        wait_drained();

        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/klx_pkg.sv
hdl/klx_scan.sv
hdl/klx_out.sv
hdl/keyword_operator_lexer_core.sv
bench/keyword_operator_lexer_checker.sv
bench/keyword_operator_lexer_core_tb.sv
